// File: sv/lblock_block_decryptor_core_assert.svh
// ----------------------------------------------------------------------------
// lblock decryptor assertion macros
// shared concurrent property forms for the decryptor core checks
// ----------------------------------------------------------------------------
`ifndef LBLOCK_BLOCK_DECRYPTOR_CORE_ASSERT_SVH
`define LBLOCK_BLOCK_DECRYPTOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LBD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// shared types, constants and s-box tables of the lblock decryptor
// ----------------------------------------------------------------------------
package lbd_pkg;

	localparam int ROUNDS    = 32;
	localparam int KEY_DEPTH = 32;
	localparam int KEY_AW    = $clog2(KEY_DEPTH);
	localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	typedef logic [3:0]  nib_t;
	typedef logic [31:0] word_t;
	typedef logic [63:0] block_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	localparam nib_t SBOX [8][16] = '{
		'{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
		  4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
		'{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
		  4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
		'{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
		  4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
		'{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
		  4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
		'{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
		  4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
		'{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
		  4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
		'{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
		  4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
		'{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
		  4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6}
	};

	// output nibble d takes substituted nibble PERM_SRC[d]
	localparam logic [2:0] PERM_SRC [8] = '{
		3'd1, 3'd3, 3'd0, 3'd2, 3'd5, 3'd7, 3'd4, 3'd6
	};

endpackage

// File: sv/lbd_round.sv
// ----------------------------------------------------------------------------
// lbd_round
// one inverse lblock round: optional half swap, f-function, xor and rotate
// ----------------------------------------------------------------------------
module lbd_round import lbd_pkg::*; (
	input  word_t lo,
	input  word_t hi,
	input  word_t key,
	input  logic  swap,
	output word_t lo_next,
	output word_t hi_next
);

	word_t lo_in;
	word_t hi_in;
	word_t x;
	word_t f_out;
	word_t v;
	nib_t  sub [8];

	assign lo_in = swap ? hi : lo;
	assign hi_in = swap ? lo : hi;
	assign x     = hi_in ^ key;

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			sub[n] = SBOX[n][x[4*n +: 4]];
		end
		for (int d = 0; d < 8; d++) begin
			f_out[4*d +: 4] = sub[PERM_SRC[d]];
		end
	end

	// xor into the low half, then rotate right by one byte
	assign v       = lo_in ^ f_out;
	assign lo_next = {v[7:0], v[31:8]};
	assign hi_next = hi_in;

endmodule

// File: sv/lblock_block_decryptor_core.sv
// ----------------------------------------------------------------------------
// lblock_block_decryptor_core
// lblock 64-bit block decryptor with a 32-entry stored round key table
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, operation, key_slot,         | sink
//          | round_key_word, cipher_block                     |
//  out     | out_valid, out_ready, plain_block               | source
//
//  a load transaction writes one key table entry
//  a decrypt transaction fetches the last key as the block is accepted,
//  then runs one round per cycle through a single shared round unit, keys read
//  from the key memory through a register in the cycle before their round
//  in_ready is low while a decrypt runs and while a finished result is
//  still held in the output register and not taken in the same cycle
//  arst_n clears the sequencer and the output valid; the key table has no
//  reset and must be written before it is used
//
module lblock_block_decryptor_core import lbd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [0:0]   operation,
	input  logic [4:0]   key_slot,
	input  logic [31:0]  round_key_word,
	input  logic [63:0]  cipher_block,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  plain_block
);

	// sequencer state
	state_t           state_q;
	state_t           state_d;
	logic [RND_W-1:0] rnd_q;
	logic             first_q;

	// datapath registers
	word_t            lo_q;
	word_t            hi_q;
	word_t            key_q;
	block_t           plain_q;
	logic             out_valid_q;

	// key table memory
	word_t            key_mem_q [KEY_DEPTH];
	logic [KEY_AW-1:0] rd_addr;

	logic             in_fire;
	logic             load_fire;
	logic             dec_fire;
	logic             last_round;
	word_t            lo_next;
	word_t            hi_next;

	assign in_fire    = in_valid && in_ready;
	assign load_fire  = in_fire && (op_t'(operation) == OP_LOAD);
	assign dec_fire   = in_fire && (op_t'(operation) == OP_DECRYPT);
	assign last_round = (state_q == ST_RUN) && (rnd_q == '0);

	// new work only when idle and the output register is free or draining
	assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign plain_block = plain_q;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (dec_fire) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_round) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// round counter counts down, key index follows it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q   <= '0;
			first_q <= 1'b0;
		end else if (dec_fire) begin
			rnd_q   <= RND_W'(ROUNDS - 1);
			first_q <= 1'b1;
		end else if (state_q == ST_RUN) begin
			rnd_q   <= rnd_q - 1'b1;
			first_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// key memory: one write port for loads, one registered read port
	// the read runs one round ahead of the datapath
	// ------------------------------------------------------------------
	assign rd_addr = (state_q == ST_RUN) ? KEY_AW'(RND_W'(rnd_q - 1'b1))
	                                     : KEY_AW'(RND_W'(ROUNDS - 1));

	always_ff @(posedge clk) begin
		if (load_fire) begin
			key_mem_q[key_slot] <= round_key_word;
		end
		key_q <= key_mem_q[rd_addr];
	end

	// ------------------------------------------------------------------
	// shared round unit, halves swapped before every round but the first
	// ------------------------------------------------------------------
	lbd_round u_round (
		.lo      (lo_q),
		.hi      (hi_q),
		.key     (key_q),
		.swap    (!first_q),
		.lo_next (lo_next),
		.hi_next (hi_next)
	);

	always_ff @(posedge clk) begin
		if (dec_fire) begin
			lo_q <= cipher_block[31:0];
			hi_q <= cipher_block[63:32];
		end else if (state_q == ST_RUN) begin
			lo_q <= lo_next;
			hi_q <= hi_next;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (last_round) begin
			plain_q <= {hi_next, lo_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_round) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`include "lblock_block_decryptor_core_assert.svh"

	`LBD_ASSERT_SAME(a_busy_not_ready, state_q == ST_RUN, !in_ready, "ready while decrypting")
	`LBD_ASSERT_NEXT(a_dec_start, dec_fire, state_q == ST_RUN && rnd_q == RND_W'(ROUNDS - 1) && first_q, "decrypt did not start at the last key")
	`LBD_ASSERT_SAME(a_out_free_at_end, last_round, !out_valid_q, "result overwrites a pending transaction")
	`LBD_ASSERT_SAME(a_out_rise_src, $rose(out_valid_q), $past(last_round), "result without a finished decrypt")

endmodule
